### rtl/core/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = 7;
	localparam int DATA_W   = 32;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		cell_op_t op;
		logic     sample;
		len_t     pos;
		word_t    key;
		len_t     count;
	} cell_ctl_t;

endpackage

### rtl/core/ple_cell.sv
// One list entry: shifts with its neighbors and flags a match or a position hit.
module ple_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ple_pkg::idx_t     idx,
	input  ple_pkg::cell_ctl_t ctl,
	input  ple_pkg::word_t    left_value,
	input  ple_pkg::word_t    right_value,
	output ple_pkg::word_t    value,
	output logic              match,
	output logic              hit
);
	import ple_pkg::*;

	word_t value_q;
	logic  match_q;
	logic  hit_q;
	len_t  idx_ext;

	assign idx_ext = {1'b0, idx};

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INS: begin
				if (idx_ext > ctl.pos) begin
					value_q <= left_value;
				end else if (idx_ext == ctl.pos) begin
					value_q <= ctl.key;
				end
			end
			CELL_REM: begin
				if (idx_ext >= ctl.pos) begin
					value_q <= right_value;
				end
			end
			default: begin
			end
		endcase
	end

	// Flags are taken from the entry as it stood before any shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			hit_q   <= 1'b0;
		end else if (ctl.sample) begin
			match_q <= (value_q == ctl.key) && (idx_ext < ctl.count);
			hit_q   <= (idx_ext == ctl.pos);
		end
	end

	assign value = value_q;
	assign match = match_q;
	assign hit   = hit_q;

endmodule

### rtl/core/ple_reduce.sv
// Collapses the per-cell flags into the first match position and the selected entry.
module ple_reduce (
	input  logic [ple_pkg::CAPACITY-1:0] match,
	input  logic [ple_pkg::CAPACITY-1:0] hit,
	input  ple_pkg::word_t               values [ple_pkg::CAPACITY],
	output logic                         any_match,
	output ple_pkg::idx_t                first_idx,
	output ple_pkg::word_t               sel_value
);
	import ple_pkg::*;

	logic [CAPACITY-1:0] lowest;

	// Isolate the lowest set bit, then encode the one-hot result.
	assign lowest    = match & (~match + {{(CAPACITY-1){1'b0}}, 1'b1});
	assign any_match = |match;

	always_comb begin
		first_idx = '0;
		sel_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (lowest[i]) begin
				first_idx = first_idx | idx_t'(i);
			end
			if (hit[i]) begin
				sel_value = sel_value | values[i];
			end
		end
	end

endmodule

### rtl/core/positional_list_engine.sv
// Top level of the positional list engine: controller, cell chain and result register.
// Each transaction is registered on accept, updates the cells and samples their flags in S_EXEC,
// then its reduced result loads the output register from S_DONE; new ones are accepted only in S_IDLE.
// The output register lets the next transaction be accepted while a result waits.
// Reset clears the entry count and the control state; the cell contents stay undefined.
module positional_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[6:0], data_in[38:7], zero fill
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // data_out[31:0], found_at[37:32], length[44:38], zero fill
	output logic [1:0]  m_tuser   // status[1:0]
);
	import ple_pkg::*;

	state_t    state_q, state_d;
	cmd_t      req_cmd_q;
	len_t      req_pos_q;
	word_t     req_key_q;
	len_t      count_q;
	status_t   status_q, exec_status;
	cell_ctl_t ctl;

	word_t               cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	logic [CAPACITY-1:0] cell_hit;

	logic  any_match;
	idx_t  first_idx;
	word_t sel_value;

	logic    out_valid_q;
	status_t out_status_q;
	word_t   out_data_q;
	idx_t    out_found_q;
	len_t    out_len_q;
	logic    out_load;
	logic    accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_cmd_q <= cmd_t'(s_tuser);
			req_pos_q <= s_tdata[6:0];
			req_key_q <= s_tdata[38:7];
		end
	end

	always_comb begin
		exec_status = ST_OK;
		case (req_cmd_q)
			CMD_INSERT: begin
				if (req_pos_q > count_q) begin
					exec_status = ST_BAD_INDEX;
				end else if (count_q >= len_t'(CAPACITY)) begin
					exec_status = ST_FULL;
				end
			end
			CMD_REMOVE, CMD_GET: begin
				if (req_pos_q >= count_q) begin
					exec_status = ST_BAD_INDEX;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.sample = (state_q == S_EXEC);
		ctl.pos    = req_pos_q;
		ctl.key    = req_key_q;
		ctl.count  = count_q;
		if (state_q == S_EXEC && exec_status == ST_OK) begin
			if (req_cmd_q == CMD_INSERT) begin
				ctl.op = CELL_INS;
			end else if (req_cmd_q == CMD_REMOVE) begin
				ctl.op = CELL_REM;
			end
		end
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.op == CELL_INS) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.op == CELL_REM) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= exec_status;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_value[i+1];
		end
		ple_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (idx_t'(i)),
			.ctl         (ctl),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cell_value[i]),
			.match       (cell_match[i]),
			.hit         (cell_hit[i])
		);
	end

	ple_reduce u_reduce (
		.match     (cell_match),
		.hit       (cell_hit),
		.values    (cell_value),
		.any_match (any_match),
		.first_idx (first_idx),
		.sel_value (sel_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_len_q <= count_q;
			if (req_cmd_q == CMD_FIND) begin
				out_status_q <= any_match ? ST_OK : ST_NOT_FOUND;
				out_found_q  <= any_match ? first_idx : '0;
				out_data_q   <= '0;
			end else begin
				out_status_q <= status_q;
				out_found_q  <= '0;
				out_data_q   <= (req_cmd_q == CMD_GET && status_q == ST_OK) ? sel_value : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_len_q, out_found_q, out_data_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= len_t'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == CELL_INS |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_NOT_FOUND |-> m_tdata[37:32] == '0)
		else $error("found_at not zero without a match");

endmodule
